FILE: rtl/wfs_pkg.sv
`timescale 1ns / 1ps

package wfs_pkg;

    // Distance scale: 1/2^DIST_FRAC_BITS cm per LSB
    localparam int DIST_FRAC_BITS = 4;
    localparam int DIST_W         = 16;

    localparam logic [DIST_W-1:0] FAR_LEFT_LIMIT     = DIST_W'(200 << DIST_FRAC_BITS);
    localparam logic [DIST_W-1:0] BIG_LEFT_LIMIT     = DIST_W'(35 << DIST_FRAC_BITS);
    localparam logic [DIST_W-1:0] CORNER_LEFT_LIMIT  = DIST_W'(25 << DIST_FRAC_BITS);
    localparam logic [DIST_W-1:0] CORNER_FRONT_LIMIT = DIST_W'(20 << DIST_FRAC_BITS);

    // Motor commands
    localparam logic [2:0] MOT_NONE  = 3'd0;
    localparam logic [2:0] MOT_FWD   = 3'd1;
    localparam logic [2:0] MOT_BACK  = 3'd2;
    localparam logic [2:0] MOT_RIGHT = 3'd3;
    localparam logic [2:0] MOT_LEFT  = 3'd4;
    localparam logic [2:0] MOT_STOP  = 3'd5;

    // Timer phases
    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_TRANS    = 4'd1;
    localparam logic [3:0] PH_CORR_R   = 4'd2;
    localparam logic [3:0] PH_CORR_L   = 4'd3;
    localparam logic [3:0] PH_TURN45   = 4'd4;
    localparam logic [3:0] PH_TURN     = 4'd5;
    localparam logic [3:0] PH_FWD      = 4'd6;
    localparam logic [3:0] PH_BACK     = 4'd7;
    localparam logic [3:0] PH_BACK_ATK = 4'd8;

    // Manoeuvre codes
    localparam logic [3:0] MV_NONE   = 4'd0;
    localparam logic [3:0] MV_CORR_R = 4'd1;
    localparam logic [3:0] MV_BIG_R  = 4'd2;
    localparam logic [3:0] MV_BIG_L  = 4'd3;
    localparam logic [3:0] MV_CORR_L = 4'd4;
    localparam logic [3:0] MV_TURN_R = 4'd5;
    localparam logic [3:0] MV_FWD_L  = 4'd6;
    localparam logic [3:0] MV_FWD_R  = 4'd7;
    localparam logic [3:0] MV_BACK   = 4'd8;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_STOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_GUARD   = 3'd5;

    typedef struct packed {
        logic              follow_enable;
        logic              attack_mode;
        logic [DIST_W-1:0] left_min;
        logic [DIST_W-1:0] left_max;
        logic [DIST_W-1:0] front_stop;
        logic [DIST_W-1:0] front_guard;
    } cfg_t;

    typedef struct packed {
        logic       first_tick;
        logic       starting;
        logic       in_transition;
        logic [3:0] manoeuvre;
        logic [1:0] right_turn_count;
    } state_t;

    typedef struct packed {
        logic [DIST_W-1:0] left_distance;
        logic [DIST_W-1:0] front_distance;
        logic              timer_expired;
    } item_t;

    typedef struct packed {
        logic [2:0] motor_cmd;
        logic       timer_reset;
        logic       timer_start;
        logic [3:0] timer_phase;
    } result_t;

endpackage

FILE: rtl/wfs_cfg.sv
`timescale 1ns / 1ps

module wfs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfs_pkg::DIST_W-1:0]     cfg_data,
    output wfs_pkg::cfg_t                  cfg
);

    wfs_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.follow_enable <= 1'b0;
            cfg_reg.attack_mode   <= 1'b0;
            cfg_reg.left_min      <= 16'd112;
            cfg_reg.left_max      <= 16'd192;
            cfg_reg.front_stop    <= 16'd160;
            cfg_reg.front_guard   <= 16'd176;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wfs_pkg::REG_FOLLOW_ENABLE: cfg_reg.follow_enable <= cfg_data[0];
                wfs_pkg::REG_ATTACK_MODE:   cfg_reg.attack_mode   <= cfg_data[0];
                wfs_pkg::REG_LEFT_MIN:      cfg_reg.left_min      <= cfg_data;
                wfs_pkg::REG_LEFT_MAX:      cfg_reg.left_max      <= cfg_data;
                wfs_pkg::REG_FRONT_STOP:    cfg_reg.front_stop    <= cfg_data;
                wfs_pkg::REG_FRONT_GUARD:   cfg_reg.front_guard   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/wfs_step.sv
`timescale 1ns / 1ps

module wfs_step (
    input  wfs_pkg::cfg_t    cfg,
    input  wfs_pkg::state_t  state,
    input  wfs_pkg::item_t   item,
    output wfs_pkg::state_t  state_next,
    output wfs_pkg::result_t result
);

    logic enabled;
    logic fired;
    logic left_lt_min, left_gt_min, left_gt_max;
    logic front_gt_stop, front_le_stop, front_lt_guard;
    logic cool;
    logic [2:0] motor;
    logic       t_reset;
    logic       t_start;
    logic [3:0] t_phase;

    assign enabled        = cfg.follow_enable | cfg.attack_mode;
    assign fired          = item.timer_expired;
    assign left_lt_min    = item.left_distance < cfg.left_min;
    assign left_gt_min    = item.left_distance > cfg.left_min;
    assign left_gt_max    = item.left_distance > cfg.left_max;
    assign front_gt_stop  = item.front_distance > cfg.front_stop;
    assign front_le_stop  = !front_gt_stop;
    assign front_lt_guard = item.front_distance < cfg.front_guard;

    always_comb begin
        state_next = state;
        cool       = 1'b0;
        motor      = wfs_pkg::MOT_NONE;
        t_reset    = 1'b0;
        t_start    = 1'b0;
        t_phase    = wfs_pkg::PH_START;

        if (enabled) begin
            if (state.first_tick) begin
                state_next.first_tick = 1'b0;
                state_next.starting   = 1'b1;
                t_start = 1'b1;
                t_phase = wfs_pkg::PH_START;
                motor   = wfs_pkg::MOT_FWD;
            end else if (state.starting) begin
                if (fired) begin
                    state_next.starting = 1'b0;
                    cool = 1'b1;
                end
            end else if (state.in_transition) begin
                if (fired) begin
                    // begin the pending phase
                    state_next.in_transition = 1'b0;
                    case (state.manoeuvre)
                        wfs_pkg::MV_CORR_R: begin
                            t_start = 1'b1;
                            t_phase = wfs_pkg::PH_CORR_R;
                            motor   = wfs_pkg::MOT_RIGHT;
                        end
                        wfs_pkg::MV_BIG_R: begin
                            t_start = 1'b1;
                            t_phase = wfs_pkg::PH_TURN45;
                            motor   = wfs_pkg::MOT_RIGHT;
                        end
                        wfs_pkg::MV_BIG_L: begin
                            t_start = 1'b1;
                            t_phase = wfs_pkg::PH_TURN45;
                            if (left_gt_min) motor = wfs_pkg::MOT_LEFT;
                        end
                        wfs_pkg::MV_CORR_L: begin
                            t_start = 1'b1;
                            t_phase = wfs_pkg::PH_CORR_L;
                            if (left_gt_min) motor = wfs_pkg::MOT_LEFT;
                        end
                        wfs_pkg::MV_TURN_R: begin
                            t_start = 1'b1;
                            t_phase = cfg.attack_mode ? wfs_pkg::PH_TURN45 : wfs_pkg::PH_TURN;
                            motor   = wfs_pkg::MOT_RIGHT;
                        end
                        wfs_pkg::MV_FWD_L: begin
                            t_start = 1'b1;
                            t_phase = wfs_pkg::PH_FWD;
                            if (!(left_lt_min || front_lt_guard)) motor = wfs_pkg::MOT_FWD;
                        end
                        wfs_pkg::MV_FWD_R: begin
                            t_start = 1'b1;
                            t_phase = wfs_pkg::PH_FWD;
                            if (cfg.attack_mode || !front_lt_guard) motor = wfs_pkg::MOT_FWD;
                        end
                        wfs_pkg::MV_BACK: begin
                            t_start = 1'b1;
                            t_phase = cfg.attack_mode ? wfs_pkg::PH_BACK_ATK : wfs_pkg::PH_BACK;
                            motor   = wfs_pkg::MOT_BACK;
                        end
                        default: begin
                            motor   = wfs_pkg::MOT_STOP;
                            t_reset = 1'b1;
                        end
                    endcase
                end
            end else begin
                case (state.manoeuvre)
                    wfs_pkg::MV_TURN_R, wfs_pkg::MV_BIG_R, wfs_pkg::MV_CORR_R: begin
                        if (fired) begin
                            state_next.manoeuvre = wfs_pkg::MV_FWD_R;
                            cool = 1'b1;
                        end
                    end
                    wfs_pkg::MV_BIG_L, wfs_pkg::MV_CORR_L: begin
                        if (fired) begin
                            state_next.manoeuvre = wfs_pkg::MV_FWD_L;
                            cool = 1'b1;
                        end else if (left_lt_min) begin
                            motor = wfs_pkg::MOT_STOP;
                        end
                    end
                    wfs_pkg::MV_BACK: begin
                        if (fired) begin
                            state_next.manoeuvre = (state.right_turn_count == 2'd2)
                                                   ? wfs_pkg::MV_BIG_R : wfs_pkg::MV_TURN_R;
                            cool = 1'b1;
                        end
                    end
                    wfs_pkg::MV_FWD_L: begin
                        if (fired) begin
                            state_next.manoeuvre = wfs_pkg::MV_NONE;
                            cool = 1'b1;
                        end else if (left_lt_min || front_lt_guard) begin
                            motor = wfs_pkg::MOT_STOP;
                        end
                    end
                    wfs_pkg::MV_FWD_R: begin
                        if (fired) begin
                            state_next.manoeuvre = wfs_pkg::MV_NONE;
                            cool = 1'b1;
                        end else if (!cfg.attack_mode && front_lt_guard) begin
                            motor = wfs_pkg::MOT_STOP;
                        end
                    end
                    default: begin
                        // idle: pick the next manoeuvre from the thresholds
                        if (item.left_distance > wfs_pkg::FAR_LEFT_LIMIT) begin
                            state_next.manoeuvre = wfs_pkg::MV_BIG_R;
                            cool = 1'b1;
                        end else if (left_lt_min && front_gt_stop) begin
                            state_next.manoeuvre = wfs_pkg::MV_CORR_R;
                            cool = 1'b1;
                        end else if (item.front_distance <= wfs_pkg::CORNER_FRONT_LIMIT &&
                                     item.left_distance > wfs_pkg::CORNER_LEFT_LIMIT) begin
                            state_next.manoeuvre = wfs_pkg::MV_BIG_R;
                            cool = 1'b1;
                        end else if (item.left_distance > wfs_pkg::BIG_LEFT_LIMIT &&
                                     front_gt_stop) begin
                            state_next.manoeuvre = wfs_pkg::MV_BIG_L;
                            cool = 1'b1;
                        end else if (left_gt_max && front_gt_stop) begin
                            state_next.manoeuvre = wfs_pkg::MV_CORR_L;
                            cool = 1'b1;
                        end else if (front_le_stop) begin
                            state_next.manoeuvre = wfs_pkg::MV_BACK;
                            if (state.right_turn_count != 2'd3) begin
                                state_next.right_turn_count = state.right_turn_count + 2'd1;
                            end
                            cool = 1'b1;
                        end else begin
                            motor = wfs_pkg::MOT_FWD;
                        end
                    end
                endcase
            end
        end

        // cool-down: stop, reset the timer and run the transition phase
        if (cool) begin
            state_next.in_transition = 1'b1;
            motor   = wfs_pkg::MOT_STOP;
            t_reset = 1'b1;
            t_start = 1'b1;
            t_phase = wfs_pkg::PH_TRANS;
        end
    end

    assign result.motor_cmd   = motor;
    assign result.timer_reset = t_reset;
    assign result.timer_start = t_start;
    assign result.timer_phase = t_start ? t_phase : wfs_pkg::PH_START;

endmodule

FILE: rtl/wall_follow_sequencer.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                            Handshake
// s_*       in   left_distance, front_distance, timer_expired      s_tvalid / s_tready
// m_*       out  motor_cmd, timer_reset, timer_start, timer_phase  m_tvalid / m_tready
// cfg_*     in   register index, write data                        cfg_valid / cfg_ready
//
// One word in per cycle while m_tready does not stall the result; a taken word waits in the input register.
// Latency is set by the input register and the result register around one
// combinational decision step; state updates as a word moves into the result register.
// Reset (aresetn low, synchronous) clears the state, both stages and the registers.
// A stalled m_tready holds the result; the input stage still takes one more word.
// cfg_ready is always high.

module wall_follow_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] left_distance, [31:16] front_distance, [32] timer_expired, [39:33] zero
    input  logic [39:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] motor_cmd, [3] timer_reset, [4] timer_start, [8:5] timer_phase, [15:9] zero
    output logic [15:0]                   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wfs_pkg::DIST_W-1:0]    cfg_data
);

    wfs_pkg::cfg_t    cfg;
    wfs_pkg::state_t  state_reg;
    wfs_pkg::state_t  state_next;
    wfs_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    wfs_pkg::result_t step_result;
    wfs_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;

    wfs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wfs_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
            state_reg.first_tick         <= 1'b1;
            state_reg.starting           <= 1'b0;
            state_reg.in_transition      <= 1'b0;
            state_reg.manoeuvre          <= wfs_pkg::MV_NONE;
            state_reg.right_turn_count   <= 2'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.left_distance  <= s_tdata[15:0];
            in_item_reg.front_distance <= s_tdata[31:16];
            in_item_reg.timer_expired  <= s_tdata[32];
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.timer_phase, out_reg.timer_start,
                       out_reg.timer_reset, out_reg.motor_cmd};

    // A phase is only reported with a timer start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.timer_start) |-> (out_reg.timer_phase == wfs_pkg::PH_START))
        else $error("timer_phase set without timer_start");

    // Timer reset with start is always the cool-down
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.timer_start && out_reg.timer_reset) |->
        (out_reg.timer_phase == wfs_pkg::PH_TRANS && out_reg.motor_cmd == wfs_pkg::MOT_STOP))
        else $error("timer reset and start outside cool-down");

    // A disabled block leaves the state untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cfg.follow_enable && !cfg.attack_mode) |=> $stable(state_reg))
        else $error("state changed while disabled");

    // The right-turn count never goes down
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (state_reg.right_turn_count >= $past(state_reg.right_turn_count)))
        else $error("right_turn_count decreased");

    // State moves only with a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a word");

endmodule

FILE: tb/wfs_cmd_checker.sv
`timescale 1ns / 1ps

module wfs_cmd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [15:0] left_distance, [31:16] front_distance, [32] timer_expired, [39:33] zero
    input  logic [39:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] motor_cmd, [3] timer_reset, [4] timer_start, [8:5] timer_phase, [15:9] zero
    input  logic [15:0]                    m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfs_pkg::DIST_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             results_seen
);

    wfs_pkg::cfg_t    seq_cfg;
    wfs_pkg::state_t  seq_st;
    wfs_pkg::result_t next_cmd;
    wfs_pkg::result_t cmd_expected[$];
    int               mismatches = 0;
    int               seen       = 0;

    function automatic void arm_timer(input logic [3:0] ph);
        next_cmd.timer_start = 1'b1;
        next_cmd.timer_phase = ph;
    endfunction

    // Stop, reset the timer and run the transition phase before the next move
    function automatic void begin_cool_down();
        next_cmd.motor_cmd   = wfs_pkg::MOT_STOP;
        next_cmd.timer_reset = 1'b1;
        arm_timer(wfs_pkg::PH_TRANS);
        seq_st.in_transition = 1'b1;
    endfunction

    function automatic void advance_sequencer(input wfs_pkg::item_t tick);
        logic [wfs_pkg::DIST_W-1:0] lft;
        logic [wfs_pkg::DIST_W-1:0] frt;
        logic                       fired;
        logic                       attack;
        lft      = tick.left_distance;
        frt      = tick.front_distance;
        fired    = tick.timer_expired;
        attack   = seq_cfg.attack_mode;
        next_cmd = '0;
        if (seq_cfg.follow_enable || attack) begin
            if (seq_st.first_tick) begin
                seq_st.first_tick = 1'b0;
                seq_st.starting   = 1'b1;
                arm_timer(wfs_pkg::PH_START);
                next_cmd.motor_cmd = wfs_pkg::MOT_FWD;
            end else if (seq_st.starting) begin
                if (fired) begin
                    seq_st.starting = 1'b0;
                    begin_cool_down();
                end
            end else if (seq_st.in_transition) begin
                if (fired) begin
                    seq_st.in_transition = 1'b0;
                    case (seq_st.manoeuvre)
                        wfs_pkg::MV_CORR_R: begin
                            arm_timer(wfs_pkg::PH_CORR_R);
                            next_cmd.motor_cmd = wfs_pkg::MOT_RIGHT;
                        end
                        wfs_pkg::MV_BIG_R: begin
                            arm_timer(wfs_pkg::PH_TURN45);
                            next_cmd.motor_cmd = wfs_pkg::MOT_RIGHT;
                        end
                        wfs_pkg::MV_BIG_L: begin
                            arm_timer(wfs_pkg::PH_TURN45);
                            if (lft > seq_cfg.left_min) next_cmd.motor_cmd = wfs_pkg::MOT_LEFT;
                        end
                        wfs_pkg::MV_CORR_L: begin
                            arm_timer(wfs_pkg::PH_CORR_L);
                            if (lft > seq_cfg.left_min) next_cmd.motor_cmd = wfs_pkg::MOT_LEFT;
                        end
                        wfs_pkg::MV_TURN_R: begin
                            arm_timer(attack ? wfs_pkg::PH_TURN45 : wfs_pkg::PH_TURN);
                            next_cmd.motor_cmd = wfs_pkg::MOT_RIGHT;
                        end
                        wfs_pkg::MV_FWD_L: begin
                            arm_timer(wfs_pkg::PH_FWD);
                            if (!(lft < seq_cfg.left_min || frt < seq_cfg.front_guard))
                                next_cmd.motor_cmd = wfs_pkg::MOT_FWD;
                        end
                        wfs_pkg::MV_FWD_R: begin
                            arm_timer(wfs_pkg::PH_FWD);
                            if (attack || !(frt < seq_cfg.front_guard))
                                next_cmd.motor_cmd = wfs_pkg::MOT_FWD;
                        end
                        wfs_pkg::MV_BACK: begin
                            arm_timer(attack ? wfs_pkg::PH_BACK_ATK : wfs_pkg::PH_BACK);
                            next_cmd.motor_cmd = wfs_pkg::MOT_BACK;
                        end
                        default: begin
                            next_cmd.motor_cmd   = wfs_pkg::MOT_STOP;
                            next_cmd.timer_reset = 1'b1;
                        end
                    endcase
                end
            end else begin
                case (seq_st.manoeuvre)
                    wfs_pkg::MV_TURN_R, wfs_pkg::MV_BIG_R, wfs_pkg::MV_CORR_R: begin
                        if (fired) begin
                            seq_st.manoeuvre = wfs_pkg::MV_FWD_R;
                            begin_cool_down();
                        end
                    end
                    wfs_pkg::MV_BIG_L, wfs_pkg::MV_CORR_L: begin
                        if (fired) begin
                            seq_st.manoeuvre = wfs_pkg::MV_FWD_L;
                            begin_cool_down();
                        end else if (lft < seq_cfg.left_min) begin
                            next_cmd.motor_cmd = wfs_pkg::MOT_STOP;
                        end
                    end
                    wfs_pkg::MV_BACK: begin
                        if (fired) begin
                            seq_st.manoeuvre = (seq_st.right_turn_count == 2'd2) ?
                                               wfs_pkg::MV_BIG_R : wfs_pkg::MV_TURN_R;
                            begin_cool_down();
                        end
                    end
                    wfs_pkg::MV_FWD_L: begin
                        if (fired) begin
                            seq_st.manoeuvre = wfs_pkg::MV_NONE;
                            begin_cool_down();
                        end else if (lft < seq_cfg.left_min || frt < seq_cfg.front_guard) begin
                            next_cmd.motor_cmd = wfs_pkg::MOT_STOP;
                        end
                    end
                    wfs_pkg::MV_FWD_R: begin
                        if (fired) begin
                            seq_st.manoeuvre = wfs_pkg::MV_NONE;
                            begin_cool_down();
                        end else if (!attack && frt < seq_cfg.front_guard) begin
                            next_cmd.motor_cmd = wfs_pkg::MOT_STOP;
                        end
                    end
                    default: begin
                        // Idle: pick the next move from the thresholds
                        if (lft > wfs_pkg::FAR_LEFT_LIMIT) begin
                            seq_st.manoeuvre = wfs_pkg::MV_BIG_R;
                            begin_cool_down();
                        end else if (lft < seq_cfg.left_min && frt > seq_cfg.front_stop) begin
                            seq_st.manoeuvre = wfs_pkg::MV_CORR_R;
                            begin_cool_down();
                        end else if (frt <= wfs_pkg::CORNER_FRONT_LIMIT &&
                                     lft > wfs_pkg::CORNER_LEFT_LIMIT) begin
                            seq_st.manoeuvre = wfs_pkg::MV_BIG_R;
                            begin_cool_down();
                        end else if (lft > wfs_pkg::BIG_LEFT_LIMIT &&
                                     frt > seq_cfg.front_stop) begin
                            seq_st.manoeuvre = wfs_pkg::MV_BIG_L;
                            begin_cool_down();
                        end else if (lft > seq_cfg.left_max && frt > seq_cfg.front_stop) begin
                            seq_st.manoeuvre = wfs_pkg::MV_CORR_L;
                            begin_cool_down();
                        end else if (frt <= seq_cfg.front_stop) begin
                            seq_st.manoeuvre = wfs_pkg::MV_BACK;
                            if (seq_st.right_turn_count != 2'd3)
                                seq_st.right_turn_count = seq_st.right_turn_count + 2'd1;
                            begin_cool_down();
                        end else begin
                            next_cmd.motor_cmd = wfs_pkg::MOT_FWD;
                        end
                    end
                endcase
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        wfs_pkg::item_t   tick;
        wfs_pkg::result_t got;
        wfs_pkg::result_t want;
        if (!aresetn) begin
            seq_cfg.follow_enable   = 1'b0;
            seq_cfg.attack_mode     = 1'b0;
            seq_cfg.left_min        = 16'd112;
            seq_cfg.left_max        = 16'd192;
            seq_cfg.front_stop      = 16'd160;
            seq_cfg.front_guard     = 16'd176;
            seq_st.first_tick       = 1'b1;
            seq_st.starting         = 1'b0;
            seq_st.in_transition    = 1'b0;
            seq_st.manoeuvre        = wfs_pkg::MV_NONE;
            seq_st.right_turn_count = 2'd0;
            cmd_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wfs_pkg::REG_FOLLOW_ENABLE: seq_cfg.follow_enable = cfg_data[0];
                    wfs_pkg::REG_ATTACK_MODE:   seq_cfg.attack_mode   = cfg_data[0];
                    wfs_pkg::REG_LEFT_MIN:      seq_cfg.left_min      = cfg_data;
                    wfs_pkg::REG_LEFT_MAX:      seq_cfg.left_max      = cfg_data;
                    wfs_pkg::REG_FRONT_STOP:    seq_cfg.front_stop    = cfg_data;
                    wfs_pkg::REG_FRONT_GUARD:   seq_cfg.front_guard   = cfg_data;
                    default: ;
                endcase
            end
            // Compare the outgoing word before queueing this edge's tick
            if (m_tvalid && m_tready) begin
                seen++;
                got.motor_cmd   = m_tdata[2:0];
                got.timer_reset = m_tdata[3];
                got.timer_start = m_tdata[4];
                got.timer_phase = m_tdata[8:5];
                if (cmd_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected command word %h, no tick outstanding",
                                 $time, m_tdata);
                end else begin
                    want = cmd_expected.pop_front();
                    if (got.motor_cmd !== want.motor_cmd ||
                        got.timer_reset !== want.timer_reset ||
                        got.timer_start !== want.timer_start ||
                        got.timer_phase !== want.timer_phase ||
                        m_tdata[15:9] !== 7'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] command mismatch exp/act: motor %0d/%0d ",
                                      "reset %b/%b start %b/%b phase %0d/%0d pad 0/%h"},
                                     $time, want.motor_cmd, got.motor_cmd,
                                     want.timer_reset, got.timer_reset,
                                     want.timer_start, got.timer_start,
                                     want.timer_phase, got.timer_phase, m_tdata[15:9]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                tick.left_distance  = s_tdata[15:0];
                tick.front_distance = s_tdata[31:16];
                tick.timer_expired  = s_tdata[32];
                advance_sequencer(tick);
                cmd_expected.push_back(next_cmd);
            end
        end
        fail_count    <= mismatches;
        pending_count <= cmd_expected.size();
        results_seen  <= seen;
    end

endmodule

FILE: tb/tb_wall_follow_sequencer.sv
`timescale 1ns / 1ps

module tb_wall_follow_sequencer;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_TICKS    = 135;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [39:0]                   s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [15:0]                   m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [wfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wfs_pkg::DIST_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending_count;
    int results_seen;
    int idle_cycles      = 0;
    int items_sent       = 0;
    int settings_applied = 0;
    bit quiet            = 1'b0;

    // Thresholds currently programmed, used to aim the distances
    logic [wfs_pkg::DIST_W-1:0] cur_left_min    = 16'd112;
    logic [wfs_pkg::DIST_W-1:0] cur_left_max    = 16'd192;
    logic [wfs_pkg::DIST_W-1:0] cur_front_stop  = 16'd160;
    logic [wfs_pkg::DIST_W-1:0] cur_front_guard = 16'd176;

    always #6 aclk = ~aclk;

    wall_follow_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wfs_cmd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .results_seen  (results_seen)
    );

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [wfs_pkg::DIST_W-1:0] near(input logic [wfs_pkg::DIST_W-1:0] v);
        return wfs_pkg::DIST_W'(int'(v) + int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic [wfs_pkg::DIST_W-1:0] pick_left();
        case ($urandom_range(0, 11))
            0:       return near(cur_left_min);
            1:       return near(cur_left_max);
            2:       return near(wfs_pkg::BIG_LEFT_LIMIT);
            3:       return near(wfs_pkg::CORNER_LEFT_LIMIT);
            4:       return near(wfs_pkg::FAR_LEFT_LIMIT);
            5:       return '0;
            6:       return '1;
            7:       return wfs_pkg::DIST_W'($urandom);
            default: return wfs_pkg::DIST_W'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [wfs_pkg::DIST_W-1:0] pick_front();
        case ($urandom_range(0, 10))
            0:       return near(cur_front_stop);
            1:       return near(cur_front_guard);
            2:       return near(wfs_pkg::CORNER_FRONT_LIMIT);
            3:       return '0;
            4:       return '1;
            5:       return wfs_pkg::DIST_W'($urandom);
            default: return wfs_pkg::DIST_W'($urandom_range(0, 1200));
        endcase
    endfunction

    // Receiver stalls
    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic [wfs_pkg::DIST_W-1:0] left,
                             input logic [wfs_pkg::DIST_W-1:0] front,
                             input logic expired);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, expired, front, left};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [wfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wfs_pkg::DIST_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Drain all outstanding commands, then program every register
    task automatic apply_setting(input logic fe, input logic am,
                                 input logic [wfs_pkg::DIST_W-1:0] lmin,
                                 input logic [wfs_pkg::DIST_W-1:0] lmax,
                                 input logic [wfs_pkg::DIST_W-1:0] fs,
                                 input logic [wfs_pkg::DIST_W-1:0] fg);
        s_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
        write_reg(wfs_pkg::REG_FOLLOW_ENABLE, {15'd0, fe});
        write_reg(wfs_pkg::REG_ATTACK_MODE, {15'd0, am});
        write_reg(wfs_pkg::REG_LEFT_MIN, lmin);
        write_reg(wfs_pkg::REG_LEFT_MAX, lmax);
        write_reg(wfs_pkg::REG_FRONT_STOP, fs);
        write_reg(wfs_pkg::REG_FRONT_GUARD, fg);
        cfg_valid <= 1'b0;
        cur_left_min    = lmin;
        cur_left_max    = lmax;
        cur_front_stop  = fs;
        cur_front_guard = fg;
        settings_applied++;
    endtask

    initial begin : stimulus
        logic                       fe;
        logic                       am;
        logic [wfs_pkg::DIST_W-1:0] lmin;
        logic [wfs_pkg::DIST_W-1:0] lmax;
        logic [wfs_pkg::DIST_W-1:0] fs;
        logic [wfs_pkg::DIST_W-1:0] fg;
        int                         n;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Block disabled after reset: idle command words only, state frozen
        send_tick('0, '0, 1'b0);
        send_tick('1, '1, 1'b1);

        apply_setting(1'b1, 1'b0, 16'd112, 16'd192, 16'd160, 16'd176);
        send_tick(16'd500, 16'd1000, 1'b0);   // start phase
        send_tick(16'd500, 16'd1000, 1'b0);   // hold, timer running
        send_tick(16'd500, 16'd1000, 1'b1);   // cool-down
        send_tick(16'd500, 16'd1000, 1'b1);   // no move pending: stop and reset
        send_tick('1, 16'd1000, 1'b0);        // far left wall
        send_tick('1, 16'd1000, 1'b1);
        send_tick(16'd100, 16'd1000, 1'b0);
        send_tick(16'd100, 16'd1000, 1'b1);
        send_tick(16'd100, 16'd1000, 1'b1);   // forward after right move
        send_tick(16'd100, 16'd100, 1'b0);    // front guard stop
        send_tick(16'd100, 16'd100, 1'b1);
        send_tick(16'd100, 16'd100, 1'b1);
        send_tick(16'd600, 16'd1000, 1'b0);   // big left correction
        send_tick(16'd100, 16'd1000, 1'b1);   // left move refused
        send_tick(16'd100, 16'd1000, 1'b0);   // too close while turning left
        send_tick(16'd100, 16'd1000, 1'b1);
        send_tick(16'd100, 16'd1000, 1'b1);   // forward after left move, blocked
        send_tick(16'd100, 16'd1000, 1'b1);
        send_tick(16'd100, 16'd1000, 1'b1);
        send_tick(16'd300, '0, 1'b0);         // backup
        send_tick(16'd300, '0, 1'b1);
        send_tick(16'd300, '0, 1'b1);         // right turn after backup

        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0, 3, 8:  {fe, am} = 2'b10;
                1, 5, 9:  {fe, am} = 2'b01;
                7:        {fe, am} = 2'b00;
                default:  {fe, am} = 2'b11;
            endcase
            case (ph)
                3: begin
                    lmin = '0; lmax = '0; fs = '0; fg = '0;
                end
                6: begin
                    lmin = '1; lmax = '1; fs = '1; fg = '1;
                end
                9: begin
                    lmin = '0; lmax = '1; fs = '1; fg = '0;
                end
                default: begin
                    lmin = wfs_pkg::DIST_W'($urandom_range(64, 192));
                    lmax = lmin + wfs_pkg::DIST_W'($urandom_range(0, 160));
                    fs   = wfs_pkg::DIST_W'($urandom_range(96, 256));
                    fg   = fs + fs / 10;
                end
            endcase
            apply_setting(fe, am, lmin, lmax, fs, fg);
            quiet = (ph % 4 == 1);
            n = (fe || am) ? PHASE_TICKS : 30;
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    send_tick(wfs_pkg::DIST_W'($urandom), wfs_pkg::DIST_W'($urandom),
                              1'($urandom));
                else
                    send_tick(pick_left(), pick_front(), $urandom_range(0, 99) < 30);
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Drove %0d sensor ticks under %0d register settings, %0d commands checked",
                 items_sent, settings_applied, results_seen);
        $display("Mismatched or unexpected commands: %0d, still outstanding: %0d",
                 fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
